// ===== rtl/core/fpf_pkg.sv =====
// ----------------------------------------------------------------------------
// fpf_pkg
// Shared types and constants of the fletcher-8 packet framer.
// ----------------------------------------------------------------------------
package fpf_pkg;

    // result group: up to eight bytes produced by one input transaction
    localparam int GRP_DEPTH = 8;
    localparam int IDX_W     = $clog2(GRP_DEPTH);

    // commands
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_NO_FRAME = 2'd2;

    // sync word after reset
    localparam logic [15:0] PREAMBLE_RESET = 16'h62B5;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        byte_t [GRP_DEPTH-1:0] bytes;     // bytes in send order, entry 0 first
        logic  [IDX_W-1:0]     last_idx;  // index of the final entry
        logic                  ends_frame; // final entry carries is_last
        logic  [1:0]           status;
    } fpf_group_t;

endpackage

// ===== rtl/core/fpf_if.sv =====
// ----------------------------------------------------------------------------
// fpf_if
// Valid/ready channel interfaces of the fletcher-8 packet framer.
// ----------------------------------------------------------------------------

// input items: frame start or payload byte
interface fpf_item_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] msg_id;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;

    modport source (output valid, command, msg_id, payload_length, data_byte, input ready);
    modport sink   (input valid, command, msg_id, payload_length, data_byte, output ready);
endinterface

// framed output byte stream
interface fpf_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_last;
    logic [1:0] status;

    modport source (output valid, out_byte, is_last, status, input ready);
    modport sink   (input valid, out_byte, is_last, status, output ready);
endinterface

// preamble register write channel
interface fpf_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/fletcher8_packet_framer.sv =====
// ----------------------------------------------------------------------------
// fletcher8_packet_framer
// Frame builder with preamble, id, length, payload and fletcher-8 checksum.
// ----------------------------------------------------------------------------
// One input transaction is taken per cycle while each produces a single output
// byte and the receiver is ready; a start gives 6 output bytes (8 with zero
// length), the last payload byte 3, errors 1. This rate is set by the output
// group register, which sends one byte per cycle unless stalled and takes the
// next transaction in the same cycle as its final byte leaves. Sums are kept in
// 8-bit registers updated by two adds per payload byte; the preamble register
// is written by the user on cfg only while the block is idle; not enforced.
module fletcher8_packet_framer #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    fpf_item_if.sink      item,
    fpf_stream_if.source  stream,
    fpf_cfg_if.sink       cfg
);
    import fpf_pkg::*;

    fpf_group_t grp;
    logic       grp_load;
    logic       grp_ready;

    // state and group builder
    fpf_engine #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (cfg),
        .grp_ready (grp_ready),
        .grp_load  (grp_load),
        .grp       (grp)
    );

    // byte sender
    fpf_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_load  (grp_load),
        .grp       (grp),
        .grp_ready (grp_ready),
        .stream    (stream)
    );

endmodule

// ===== rtl/core/fpf_engine.sv =====
// ----------------------------------------------------------------------------
// fpf_engine
// Frame state, running fletcher sums and result group builder.
// ----------------------------------------------------------------------------
module fpf_engine #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    fpf_item_if.sink           item,
    fpf_cfg_if.sink            cfg,
    input  logic               grp_ready,
    output logic               grp_load,
    output fpf_pkg::fpf_group_t grp
);
    import fpf_pkg::*;

    localparam int LEFT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

    logic [15:0]       preamble_reg;
    logic [7:0]        sum_a_reg, sum_a_next;
    logic [7:0]        sum_b_reg, sum_b_next;
    logic [LEFT_W-1:0] bytes_left_reg, bytes_left_next;
    logic              frame_open_reg, frame_open_next;

    logic              accept;
    logic              too_long;
    logic [7:0]        a1, a2, a3, a4, b4;
    logic [7:0]        pa, pb;

    // handshakes
    assign item.ready = grp_ready;
    assign cfg.ready  = 1'b1;
    assign accept     = item.valid && item.ready;
    assign grp_load   = accept;
    assign too_long   = item.payload_length > MAX_LEN;

    // header sums over id and length bytes, from zero
    always_comb
    begin
        a1 = item.msg_id[7:0];
        a2 = a1 + item.msg_id[15:8];
        a3 = a2 + item.payload_length[7:0];
        a4 = a3 + item.payload_length[15:8];
        b4 = a1 + a2 + a3 + a4;
    end

    // payload byte sums
    assign pa = sum_a_reg + item.data_byte;
    assign pb = sum_b_reg + pa;

    // result group and next state
    always_comb
    begin
        grp             = '0;
        grp.status      = ST_OK;
        sum_a_next      = sum_a_reg;
        sum_b_next      = sum_b_reg;
        bytes_left_next = bytes_left_reg;
        frame_open_next = frame_open_reg;
        if (item.command == CMD_START)
        begin
            if (too_long)
            begin
                grp.status      = ST_TOO_LONG;
                bytes_left_next = '0;
                frame_open_next = 1'b0;
            end
            else
            begin
                grp.bytes[0] = preamble_reg[7:0];
                grp.bytes[1] = preamble_reg[15:8];
                grp.bytes[2] = item.msg_id[7:0];
                grp.bytes[3] = item.msg_id[15:8];
                grp.bytes[4] = item.payload_length[7:0];
                grp.bytes[5] = item.payload_length[15:8];
                grp.bytes[6] = a4;
                grp.bytes[7] = b4;
                sum_a_next   = a4;
                sum_b_next   = b4;
                if (item.payload_length == 16'd0)
                begin
                    grp.last_idx    = IDX_W'(7);
                    grp.ends_frame  = 1'b1;
                    bytes_left_next = '0;
                    frame_open_next = 1'b0;
                end
                else
                begin
                    grp.last_idx    = IDX_W'(5);
                    bytes_left_next = item.payload_length[LEFT_W-1:0];
                    frame_open_next = 1'b1;
                end
            end
        end
        else if (!frame_open_reg || bytes_left_reg == '0)
        begin
            grp.status = ST_NO_FRAME;
        end
        else
        begin
            grp.bytes[0] = item.data_byte;
            grp.bytes[1] = pa;
            grp.bytes[2] = pb;
            sum_a_next   = pa;
            sum_b_next   = pb;
            if (bytes_left_reg == LEFT_W'(1))
            begin
                grp.last_idx    = IDX_W'(2);
                grp.ends_frame  = 1'b1;
                bytes_left_next = '0;
                frame_open_next = 1'b0;
            end
            else
            begin
                bytes_left_next = bytes_left_reg - LEFT_W'(1);
            end
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_a_reg      <= '0;
            sum_b_reg      <= '0;
            bytes_left_reg <= '0;
            frame_open_reg <= 1'b0;
        end
        else if (accept)
        begin
            sum_a_reg      <= sum_a_next;
            sum_b_reg      <= sum_b_next;
            bytes_left_reg <= bytes_left_next;
            frame_open_reg <= frame_open_next;
        end
    end

    // preamble register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            preamble_reg <= PREAMBLE_RESET;
        else if (cfg.valid && cfg.ready)
            preamble_reg <= cfg.data;
    end

    // an open frame always expects at least one more byte
    a_open_left: assert property (@(posedge clk) disable iff (!rst_n)
        frame_open_reg == (bytes_left_reg != '0))
        else $error("frame_open and bytes_left disagree");

    // an over-long start closes any frame
    a_long_close: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.command == CMD_START && too_long |=> !frame_open_reg)
        else $error("frame left open after length error");

    // a payload transaction into an open frame consumes one byte
    a_left_dec: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.command == CMD_PAYLOAD && frame_open_reg
        |=> bytes_left_reg == $past(bytes_left_reg) - LEFT_W'(1))
        else $error("bytes_left not decremented");

endmodule

// ===== rtl/core/fpf_serializer.sv =====
// ----------------------------------------------------------------------------
// fpf_serializer
// Result group register that sends its bytes one per transaction.
// ----------------------------------------------------------------------------
module fpf_serializer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                grp_load,
    input  fpf_pkg::fpf_group_t grp,
    output logic                grp_ready,
    fpf_stream_if.source        stream
);
    import fpf_pkg::*;

    fpf_group_t        grp_reg;
    logic              valid_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              take;
    logic              done;

    // output handshake
    assign take      = stream.valid && stream.ready;
    assign done      = take && idx_reg == grp_reg.last_idx;
    assign grp_ready = !valid_reg || done;

    assign stream.valid    = valid_reg;
    assign stream.out_byte = grp_reg.bytes[idx_reg];
    assign stream.is_last  = grp_reg.ends_frame && idx_reg == grp_reg.last_idx;
    assign stream.status   = grp_reg.status;

    // group payload
    always_ff @(posedge clk)
    begin
        if (grp_load)
            grp_reg <= grp;
    end

    // send control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (grp_load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (done)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // index never runs past the group
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> idx_reg <= grp_reg.last_idx)
        else $error("send index beyond group");

    // is_last only on ok results
    a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && stream.is_last |-> stream.status == ST_OK)
        else $error("is_last on error result");

    // group drains when the final byte goes and nothing new arrives
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        done && !grp_load |=> !valid_reg)
        else $error("group not released after final byte");

endmodule

// ===== tb/tb_fletcher8_packet_framer.sv =====
// ----------------------------------------------------------------------------
// tb_fletcher8_packet_framer
// Drives start and payload transactions into the framer and predicts every
// byte of the framed stream: preamble, id, length, payload and the two
// fletcher-8 checksum bytes, plus the too-long and no-frame error results.
// Each output transaction is checked against the oldest predicted byte.
// Covers directed corner cases, a full-size frame and random frame traffic
// under several preamble settings, with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_fletcher8_packet_framer;
    timeunit 1ns;
    timeprecision 1ps;

    import fpf_pkg::*;

    localparam int MAX_FRAME_PAYLOAD = 64;
    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int SETTLE_CYCLES     = 12;
    localparam int RANDOM_ITEMS      = 80;

    // rx stall modes
    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    // one predicted byte of the framed stream
    typedef struct packed {
        byte_t      out_byte;
        logic       is_last;
        logic [1:0] status;
    } framed_byte_t;

    logic clk;
    logic rst_n;

    fpf_item_if   item_ch();
    fpf_stream_if stream_ch();
    fpf_cfg_if    cfg_ch();

    fletcher8_packet_framer #(
        .MAX_PAYLOAD(MAX_FRAME_PAYLOAD)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .stream (stream_ch),
        .cfg    (cfg_ch)
    );

    // predicted framer state
    logic [15:0]  sync_word;
    byte_t        run_a;
    byte_t        run_b;
    int           payload_left;
    logic         frame_open;
    framed_byte_t expected_bytes[$];

    // traffic shaping
    int  fail_count;
    int  items_sent;
    int  burst_left;
    bit  sender_gaps;
    int  rx_mode;
    int  rx_tick;

    // clock generation
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void push_byte(input byte_t value, input logic last,
                                      input logic [1:0] st);
        framed_byte_t entry;
        entry.out_byte = value;
        entry.is_last  = last;
        entry.status   = st;
        expected_bytes.push_back(entry);
    endfunction

    function automatic void fold_sum(input byte_t value);
        run_a = run_a + value;
        run_b = run_b + run_a;
    endfunction

    function automatic void close_frame();
        push_byte(run_a, 1'b0, ST_OK);
        push_byte(run_b, 1'b1, ST_OK);
        frame_open   = 1'b0;
        payload_left = 0;
    endfunction

    function automatic bit payload_length_done();
        return payload_left == 0;
    endfunction

    // work out the stream bytes caused by one accepted transaction
    function automatic void predict_frame_bytes(input logic cmd, input logic [15:0] id,
                                                input logic [15:0] len, input byte_t data);
        if (cmd == CMD_START)
        begin
            if (len > MAX_FRAME_PAYLOAD)
            begin
                frame_open   = 1'b0;
                payload_left = 0;
                push_byte(8'h00, 1'b0, ST_TOO_LONG);
            end
            else
            begin
                push_byte(sync_word[7:0], 1'b0, ST_OK);
                push_byte(sync_word[15:8], 1'b0, ST_OK);
                push_byte(id[7:0], 1'b0, ST_OK);
                push_byte(id[15:8], 1'b0, ST_OK);
                push_byte(len[7:0], 1'b0, ST_OK);
                push_byte(len[15:8], 1'b0, ST_OK);
                run_a = 8'h00;
                run_b = 8'h00;
                fold_sum(id[7:0]);
                fold_sum(id[15:8]);
                fold_sum(len[7:0]);
                fold_sum(len[15:8]);
                if (len == 16'd0)
                begin
                    close_frame();
                end
                else
                begin
                    payload_left = int'(len);
                    frame_open   = 1'b1;
                end
            end
        end
        else if (!frame_open || payload_left == 0)
        begin
            push_byte(8'h00, 1'b0, ST_NO_FRAME);
        end
        else
        begin
            push_byte(data, 1'b0, ST_OK);
            fold_sum(data);
            payload_left--;
            if (payload_length_done())
            begin
                close_frame();
            end
        end
    endfunction

    // send one input transaction, with bursts and gaps on the sender side
    task automatic send_item(input logic cmd, input logic [15:0] id,
                             input logic [15:0] len, input byte_t data);
        int gap;
        if (sender_gaps && burst_left == 0)
        begin
            item_ch.valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        item_ch.valid          <= 1'b1;
        item_ch.command        <= cmd;
        item_ch.msg_id         <= id;
        item_ch.payload_length <= len;
        item_ch.data_byte      <= data;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        predict_frame_bytes(cmd, id, len, data);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        items_sent++;
    endtask

    task automatic send_start(input logic [15:0] id, input logic [15:0] len);
        send_item(CMD_START, id, len, byte_t'($urandom));
    endtask

    task automatic send_payload(input byte_t data);
        send_item(CMD_PAYLOAD, 16'($urandom), 16'($urandom), data);
    endtask

    // hold the sender until every predicted byte has left the block
    task automatic idle_framer();
        item_ch.valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // preamble register write, only while the block is idle
    task automatic write_preamble(input logic [15:0] word);
        idle_framer();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= word;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        sync_word = word;
    endtask

    // zero length frames under the reset preamble
    task automatic test_zero_length();
        send_start(16'h0000, 16'd0);
        send_start(16'hFFFF, 16'd0);
    endtask

    // payload bytes with no open frame
    task automatic test_stray_payload();
        send_payload(8'hFF);
        send_payload(8'h00);
    endtask

    // lengths just above the limit and at the top of the field
    task automatic test_too_long();
        send_start(16'h1357, 16'(MAX_FRAME_PAYLOAD + 1));
        send_start(16'hFFFF, 16'hFFFF);
    endtask

    // sums wrapping on all-ones bytes
    task automatic test_sum_wrap();
        send_start(16'hFFFF, 16'd3);
        send_payload(8'hFF);
        send_payload(8'hFF);
        send_payload(8'h00);
    endtask

    // a start while a frame is still open drops the old frame
    task automatic test_restart_open_frame();
        send_start(16'h00A5, 16'd4);
        send_payload(8'h11);
        send_start(16'h5A00, 16'd1);
        send_payload(8'h22);
    endtask

    // a too-long start also closes the open frame
    task automatic test_too_long_aborts();
        send_start(16'h0F0F, 16'd2);
        send_payload(8'h33);
        send_start(16'hF0F0, 16'd100);
        send_payload(8'h44);
    endtask

    // preamble register at both extremes, then back to the reset word
    task automatic test_preamble_extremes();
        write_preamble(16'h0000);
        send_start(16'h5A5A, 16'd0);
        write_preamble(16'hFFFF);
        send_start(16'hC3A5, 16'd1);
        send_payload(8'h80);
        write_preamble(PREAMBLE_RESET);
    endtask

    // largest frame the block accepts
    task automatic test_max_length();
        send_start(16'($urandom), 16'(MAX_FRAME_PAYLOAD));
        for (int i = 0; i < MAX_FRAME_PAYLOAD; i++)
        begin
            send_payload(byte_t'($urandom));
        end
    endtask

    // random frame traffic over several preamble settings and idle modes
    task automatic test_random_traffic();
        int first_item;
        int kind;
        int pick;
        int len;
        int cut;
        first_item = items_sent;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_preamble(16'($urandom));
            if (phase == 0)
            begin
                sender_gaps = 1'b0;
                rx_mode     = RX_ALWAYS;
            end
            else
            begin
                sender_gaps = 1'b1;
                rx_mode     = $urandom_range(RX_ALWAYS, RX_PATTERN);
            end
            burst_left = $urandom_range(1, 12);
            while (items_sent - first_item < (phase + 1) * RANDOM_ITEMS / 4)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 72)
                begin
                    // well-formed frame
                    pick = $urandom_range(0, 99);
                    if (pick < 5)
                        len = MAX_FRAME_PAYLOAD;
                    else if (pick < 70)
                        len = $urandom_range(0, 8);
                    else
                        len = $urandom_range(9, 40);
                    send_start(16'($urandom), 16'(len));
                    for (int i = 0; i < len; i++)
                    begin
                        send_payload(byte_t'($urandom));
                    end
                end
                else if (kind < 82)
                begin
                    // frame cut short, left open
                    len = $urandom_range(2, 20);
                    cut = $urandom_range(0, len - 1);
                    send_start(16'($urandom), 16'(len));
                    for (int i = 0; i < cut; i++)
                    begin
                        send_payload(byte_t'($urandom));
                    end
                end
                else if (kind < 91)
                begin
                    send_start(16'($urandom), 16'($urandom_range(MAX_FRAME_PAYLOAD + 1, 65535)));
                end
                else
                begin
                    send_payload(byte_t'($urandom));
                end
            end
        end
    endtask

    // stream checker and receiver stall pattern
    always @(posedge clk)
    begin : stream_monitor
        framed_byte_t want;
        logic [15:0]  stall_mask;
        stall_mask = 16'b1110_1101_0011_1110;
        if (rst_n)
        begin
            if (stream_ch.valid && stream_ch.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected stream byte %0h (is_last %0b, status %0d)",
                           stream_ch.out_byte, stream_ch.is_last, stream_ch.status);
                    fail_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (stream_ch.out_byte !== want.out_byte)
                    begin
                        $error("out_byte mismatch: expected %0h, actual %0h",
                               want.out_byte, stream_ch.out_byte);
                        fail_count++;
                    end
                    if (stream_ch.is_last !== want.is_last)
                    begin
                        $error("is_last mismatch: expected %0b, actual %0b",
                               want.is_last, stream_ch.is_last);
                        fail_count++;
                    end
                    if (stream_ch.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, stream_ch.status);
                        fail_count++;
                    end
                end
            end
            rx_tick++;
            case (rx_mode)
                RX_RANDOM:  stream_ch.ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: stream_ch.ready <= stall_mask[rx_tick % 16];
                default:    stream_ch.ready <= 1'b1;
            endcase
        end
        else
        begin
            stream_ch.ready <= 1'b0;
        end
    end

    // watchdog on cycles with no transaction on any channel
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (item_ch.valid && item_ch.ready)
                || (stream_ch.valid && stream_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // reset, test sequence and final verdict
    initial
    begin
        fail_count   = 0;
        items_sent   = 0;
        burst_left   = 0;
        sender_gaps  = 1'b0;
        rx_mode      = RX_ALWAYS;
        rx_tick      = 0;
        sync_word    = PREAMBLE_RESET;
        run_a        = 8'h00;
        run_b        = 8'h00;
        payload_left = 0;
        frame_open   = 1'b0;

        rst_n                  <= 1'b0;
        item_ch.valid          <= 1'b0;
        item_ch.command        <= CMD_START;
        item_ch.msg_id         <= 16'h0000;
        item_ch.payload_length <= 16'h0000;
        item_ch.data_byte      <= 8'h00;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.data            <= 16'h0000;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_length();
        test_stray_payload();
        test_too_long();
        test_sum_wrap();
        test_restart_open_frame();
        test_too_long_aborts();
        test_preamble_extremes();

        sender_gaps = 1'b1;
        rx_mode     = RX_PATTERN;
        test_max_length();
        test_random_traffic();

        idle_framer();
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
